@@ src/osc_apv_pkg.sv @@
// Shared constants, beat struct and character classes for the OSC address
// pattern validator. No dependencies.
package osc_apv_pkg;

  localparam int unsigned MAX_SEGMENTS = 255;
  localparam int unsigned SEG_CAP      = (MAX_SEGMENTS < 255) ? MAX_SEGMENTS : 255;
  localparam logic [7:0]  SEG_CAP_W    = 8'(SEG_CAP);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_QMARK  = 8'h3f;

  // One registered input byte handed to the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } beat_t;

  function automatic logic is_printable(input logic [7:0] c);
    return (c >= CH_SPACE) && (c < CH_DEL);
  endfunction

  function automatic logic is_valid_char(input logic [7:0] c);
    logic special;
    special = (c == CH_SPACE) || (c == CH_HASH) || (c == CH_STAR) ||
              (c == CH_COMMA) || (c == CH_SLASH) || (c == CH_QMARK) ||
              (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_LBRACE) ||
              (c == CH_RBRACE);
    return is_printable(c) && !special;
  endfunction

endpackage

@@ src/osc_apv_in_reg.sv @@
// Input register stage: captures one pattern byte per beat.
// Depends on osc_apv_pkg.
module osc_apv_in_reg
  import osc_apv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       hold,
  output beat_t      beat
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] ch_r;

  assign in_stall  = valid_r && hold;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload loads whenever the stage is free to advance.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      ch_r <= in_char_in;
    end
  end

  assign beat.valid = valid_r;
  assign beat.ch    = ch_r;

endmodule

@@ src/osc_apv_parser.sv @@
// Grammar state machine and result register of the pattern validator.
// Depends on osc_apv_pkg.
module osc_apv_parser
  import osc_apv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  beat_t      beat,
  output logic       hold,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_status,
  output logic [7:0] out_segment_count
);

  typedef enum logic [3:0] {
    PH_START, PH_SEG_FIRST, PH_BODY, PH_LIST, PH_RANGE_OPEN,
    PH_RANGE_EMPTY, PH_RANGE_ITEM, PH_RANGE_DASH, PH_RANGE_AFTER, PH_BAD
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] seg_r, seg_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       status_r, status_nxt;
  logic [7:0] count_r, count_nxt;

  logic       is_end;
  logic       fire;
  logic       vc;
  logic [7:0] c;
  phase_t     body_ph;
  logic [7:0] body_seg;
  phase_t     range_more_ph;

  assign c      = beat.ch;
  assign vc     = is_valid_char(c);
  assign is_end = (c == CH_NUL);
  // Hold only an end byte while the previous result is still unclaimed.
  assign hold   = is_end && out_valid_r && out_stall;
  assign fire   = beat.valid && !hold;

  always_comb begin
    body_seg = seg_r;
    priority if (c == CH_SLASH) begin
      body_ph = PH_SEG_FIRST;
      if (seg_r < SEG_CAP_W) body_seg = seg_r + 8'd1;
    end else if (c == CH_LBRACE) begin
      body_ph = PH_LIST;
    end else if (c == CH_LBRACK) begin
      body_ph = PH_RANGE_OPEN;
    end else if ((c == CH_STAR) || (c == CH_QMARK)) begin
      body_ph = PH_BODY;
    end else if ((c == CH_SPACE) || (c == CH_HASH) || (c == CH_RBRACK) ||
                 (c == CH_RBRACE) || (c == CH_COMMA)) begin
      body_ph = PH_BAD;
    end else begin
      body_ph = is_printable(c) ? PH_BODY : PH_BAD;
    end
  end

  always_comb begin
    if (vc) range_more_ph = PH_RANGE_ITEM;
    else if (c == CH_RBRACK) range_more_ph = PH_BODY;
    else range_more_ph = PH_BAD;
  end

  always_comb begin
    phase_nxt     = phase_r;
    seg_nxt       = seg_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    count_nxt     = count_r;
    if (fire) begin
      if (is_end) begin
        out_valid_nxt = 1'b1;
        status_nxt    = (phase_r != PH_BODY);
        count_nxt     = (phase_r == PH_BODY) ? seg_r : 8'd0;
        phase_nxt     = PH_START;
        seg_nxt       = 8'd0;
      end else begin
        unique case (phase_r)
          PH_START: begin
            if (c == CH_SLASH) begin
              seg_nxt   = 8'd1;
              phase_nxt = PH_SEG_FIRST;
            end else begin
              phase_nxt = PH_BAD;
            end
          end
          PH_SEG_FIRST: begin
            if (c == CH_SLASH) begin
              phase_nxt = PH_BAD;
            end else begin
              phase_nxt = body_ph;
              seg_nxt   = body_seg;
            end
          end
          PH_BODY: begin
            phase_nxt = body_ph;
            seg_nxt   = body_seg;
          end
          PH_LIST: begin
            if (c == CH_RBRACE) phase_nxt = PH_BODY;
            else if ((c == CH_COMMA) || vc) phase_nxt = PH_LIST;
            else phase_nxt = PH_BAD;
          end
          PH_RANGE_OPEN: begin
            if (c == CH_BANG) phase_nxt = PH_RANGE_EMPTY;
            else phase_nxt = vc ? PH_RANGE_ITEM : PH_BAD;
          end
          PH_RANGE_EMPTY: phase_nxt = vc ? PH_RANGE_ITEM : PH_BAD;
          PH_RANGE_ITEM: begin
            phase_nxt = (c == CH_DASH) ? PH_RANGE_DASH : range_more_ph;
          end
          PH_RANGE_DASH:  phase_nxt = vc ? PH_RANGE_AFTER : PH_BAD;
          PH_RANGE_AFTER: phase_nxt = range_more_ph;
          default:        phase_nxt = PH_BAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      seg_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    count_r  <= count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_segment_count = count_r;

endmodule

@@ src/osc_address_pattern_validator.sv @@
// OSC address pattern syntax checker: one pattern byte per beat, one result
// per zero byte. A zero byte passes the input register, then the parser's
// result register, where its result shows as valid.
// Throughput: 1 byte per cycle; an end byte waits only while the previous
// result is still stalled at the output register.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of a pattern with no segments counted.
module osc_address_pattern_validator
  import osc_apv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_status,
  output logic [7:0] out_segment_count
);

  beat_t beat;
  logic  hold;

  osc_apv_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .hold       (hold),
    .beat       (beat)
  );

  osc_apv_parser u_parser (
    .clk               (clk),
    .rst_n             (rst_n),
    .beat              (beat),
    .hold              (hold),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_segment_count (out_segment_count)
  );

endmodule

@@ sim/osc_apv_checker.sv @@
`timescale 1ns / 1ps
// Checker for the OSC address pattern validator: tracks the pattern grammar on accepted
// input beats, queues the expected verdicts and compares every accepted result beat.
// Depends on osc_apv_pkg for the character constants and the segment cap.
module osc_apv_checker
  import osc_apv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_status,
  input  logic [7:0] out_segment_count,
  output int         fail_count,
  output int         pending,
  output int         verdicts_checked,
  output int         clean_verdicts
);

  typedef enum logic [3:0] {
    PS_START,
    PS_SEG_FIRST,
    PS_BODY,
    PS_LIST,
    PS_RANGE_OPEN,
    PS_RANGE_EMPTY,
    PS_RANGE_ITEM,
    PS_RANGE_DASH,
    PS_RANGE_AFTER,
    PS_BAD
  } grammar_state_t;

  typedef struct packed {
    logic       status;
    logic [7:0] seg_count;
  } verdict_t;

  grammar_state_t gstate;
  logic [7:0]     seg_tally;
  verdict_t       verdicts_due[$];
  int             err_tally;
  int             checked_tally;
  int             clean_tally;

  // Printable and not one of the pattern's reserved characters.
  function automatic logic plain_char(input logic [7:0] c);
    if (c < CH_SPACE || c >= CH_DEL) return 1'b0;
    case (c)
      CH_SPACE, CH_HASH, CH_STAR, CH_COMMA, CH_SLASH,
      CH_QMARK, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE: return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  function automatic grammar_state_t after_body(input logic [7:0] c);
    case (c)
      CH_SLASH:                                    return PS_SEG_FIRST;
      CH_LBRACE:                                   return PS_LIST;
      CH_LBRACK:                                   return PS_RANGE_OPEN;
      CH_STAR, CH_QMARK:                           return PS_BODY;
      CH_SPACE, CH_HASH, CH_RBRACK, CH_RBRACE, CH_COMMA: return PS_BAD;
      default: return (c >= CH_SPACE && c < CH_DEL) ? PS_BODY : PS_BAD;
    endcase
  endfunction

  // Range with at least one item and no dash waiting.
  function automatic grammar_state_t range_tail(input logic [7:0] c);
    if (plain_char(c)) return PS_RANGE_ITEM;
    return (c == CH_RBRACK) ? PS_BODY : PS_BAD;
  endfunction

  task automatic advance_grammar(input logic [7:0] c);
    verdict_t v;
    if (c == CH_NUL) begin
      v.status    = (gstate != PS_BODY);
      v.seg_count = v.status ? 8'd0 : seg_tally;
      verdicts_due.push_back(v);
      gstate    = PS_START;
      seg_tally = '0;
    end else begin
      case (gstate)
        PS_START: begin
          if (c == CH_SLASH) begin
            seg_tally = 8'd1;
            gstate    = PS_SEG_FIRST;
          end else begin
            gstate = PS_BAD;
          end
        end
        PS_SEG_FIRST: gstate = (c == CH_SLASH) ? PS_BAD : after_body(c);
        PS_BODY: begin
          // count saturates, the pattern stays acceptable
          if (c == CH_SLASH && seg_tally < SEG_CAP_W) seg_tally++;
          gstate = after_body(c);
        end
        PS_LIST: begin
          if (c == CH_RBRACE) gstate = PS_BODY;
          else if (c == CH_COMMA || plain_char(c)) gstate = PS_LIST;
          else gstate = PS_BAD;
        end
        PS_RANGE_OPEN: begin
          if (c == CH_BANG) gstate = PS_RANGE_EMPTY;
          else gstate = plain_char(c) ? PS_RANGE_ITEM : PS_BAD;
        end
        PS_RANGE_EMPTY: gstate = plain_char(c) ? PS_RANGE_ITEM : PS_BAD;
        PS_RANGE_ITEM:  gstate = (c == CH_DASH) ? PS_RANGE_DASH : range_tail(c);
        PS_RANGE_DASH:  gstate = plain_char(c) ? PS_RANGE_AFTER : PS_BAD;
        PS_RANGE_AFTER: gstate = range_tail(c);
        default:        gstate = PS_BAD;
      endcase
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      gstate        = PS_START;
      seg_tally     = '0;
      err_tally     = 0;
      checked_tally = 0;
      clean_tally   = 0;
      verdicts_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          if (err_tally < 10)
            $display("checker: result beat with nothing expected, status %0d count %0d",
                     out_status, out_segment_count);
          err_tally++;
        end else begin
          want = verdicts_due.pop_front();
          checked_tally++;
          if (!want.status) clean_tally++;
          if (out_status !== want.status || out_segment_count !== want.seg_count) begin
            if (err_tally < 10)
              $display("checker: mismatch at %0t, expected status %0d count %0d, got %0d %0d",
                       $realtime, want.status, want.seg_count, out_status, out_segment_count);
            err_tally++;
          end
        end
      end
      if (in_valid && !in_stall) advance_grammar(in_char_in);
    end
    fail_count       <= err_tally;
    pending          <= verdicts_due.size();
    verdicts_checked <= checked_tally;
    clean_verdicts   <= clean_tally;
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Top of the OSC address pattern validator bench: clock, reset, pattern stimulus,
// result-side stalls and the verdict. Depends on osc_apv_pkg, the RTL and osc_apv_checker.
module testbench;
  import osc_apv_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned BYTE_TARGET = 1850;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_in;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_status;
  logic [7:0] out_segment_count;

  int fail_count;
  int pending;
  int verdicts_checked;
  int clean_verdicts;
  int patterns_sent = 0;
  int bytes_sent    = 0;

  logic [7:0]  pat_bytes[$];
  int unsigned stall_hold   = 0;
  int unsigned quiet_cycles = 0;

  // every character a segment may hold as a plain character
  string legal_pool =
    "!\"$%&'()+-.0123456789:;<=>@ABCDEFGHIJKLMNOPQRSTUVWXYZ\\^_`abcdefghijklmnopqrstuvwxyz|~";

  always #10 clk = ~clk;

  osc_address_pattern_validator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_in        (in_char_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_segment_count (out_segment_count)
  );

  osc_apv_checker u_grammar_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_in        (in_char_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_segment_count (out_segment_count),
    .fail_count        (fail_count),
    .pending           (pending),
    .verdicts_checked  (verdicts_checked),
    .clean_verdicts    (clean_verdicts)
  );

  function automatic logic [7:0] pick_legal();
    return 8'(legal_pool[$urandom_range(0, legal_pool.len() - 1)]);
  endfunction

  // Hold the beat until accepted, then maybe idle for a while.
  task automatic push_byte(input logic [7:0] c, input bit calm);
    int unsigned r;
    int unsigned gap;
    in_valid   <= 1'b1;
    in_char_in <= c;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    r = $urandom_range(0, 99);
    if (calm || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(6, 40);
    if (gap != 0) begin
      in_valid   <= 1'b0;
      in_char_in <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_pattern(input bit calm);
    foreach (pat_bytes[i]) push_byte(pat_bytes[i], calm);
    push_byte(CH_NUL, calm);
    patterns_sent++;
  endtask

  task automatic send_text(input string s);
    pat_bytes.delete();
    for (int i = 0; i < s.len(); i++) pat_bytes.push_back(8'(s[i]));
    send_pattern(1'b0);
  endtask

  // result side: short stalls, some long ones, and long calm stretches
  always @(posedge clk) begin
    int unsigned r;
    if (stall_hold == 0) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        out_stall  <= 1'b0;
        stall_hold = $urandom_range(1, 8);
      end else if (r < 80) begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(1, 3);
      end else if (r < 88) begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(10, 40);
      end else begin
        out_stall  <= 1'b0;
        stall_hold = $urandom_range(40, 150);
      end
    end
    stall_hold--;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned nseg;
    int unsigned nitem;
    int unsigned kind;
    bit          calm;
    in_valid   = 1'b0;
    in_char_in = 8'h00;
    rst_n      = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed patterns: grammar corners and byte extremes
    send_text("");
    send_text("abc");
    send_text("/");
    send_text("//x");
    send_text("/a/");
    send_text("/a b");
    send_text("/a#");
    send_text("/a]");
    send_text("/a}");
    send_text("/a,");
    send_text("/{b,,c}d");
    send_text("/{b/");
    send_text("/{b");
    send_text("/[!a-z]");
    send_text("/[]");
    send_text("/[!]");
    send_text("/[a-]");
    send_text("/[a-b-c]");
    send_text("/[a");
    send_text("/*?/x");
    pat_bytes = '{CH_SLASH, 8'h01};
    send_pattern(1'b0);
    pat_bytes = '{CH_SLASH, 8'h61, 8'hff};
    send_pattern(1'b0);
    // more segments than the counter holds
    pat_bytes.delete();
    repeat (300) begin
      pat_bytes.push_back(CH_SLASH);
      pat_bytes.push_back(pick_legal());
    end
    send_pattern(1'b0);

    // random patterns: mostly well formed, some damaged, some noise
    while (bytes_sent < BYTE_TARGET) begin
      pat_bytes.delete();
      nseg = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 4);
      repeat (nseg) begin
        pat_bytes.push_back(CH_SLASH);
        repeat ($urandom_range(1, 4)) begin
          kind = $urandom_range(0, 9);
          if (kind < 5) begin
            pat_bytes.push_back(pick_legal());
          end else if (kind == 5) begin
            pat_bytes.push_back($urandom_range(0, 1) ? CH_STAR : CH_QMARK);
          end else if (kind < 8) begin
            pat_bytes.push_back(CH_LBRACE);
            nitem = $urandom_range(0, 3);
            for (int i = 0; i < nitem; i++) begin
              if (i != 0) pat_bytes.push_back(CH_COMMA);
              repeat ($urandom_range(0, 2)) pat_bytes.push_back(pick_legal());
            end
            pat_bytes.push_back(CH_RBRACE);
          end else begin
            pat_bytes.push_back(CH_LBRACK);
            if ($urandom_range(0, 3) == 0) pat_bytes.push_back(CH_BANG);
            repeat ($urandom_range(1, 3)) begin
              pat_bytes.push_back(pick_legal());
              if ($urandom_range(0, 2) == 0) begin
                pat_bytes.push_back(CH_DASH);
                pat_bytes.push_back(pick_legal());
              end
            end
            pat_bytes.push_back(CH_RBRACK);
          end
        end
      end
      kind = $urandom_range(0, 9);
      if (kind == 6 || kind == 7) begin
        // overwrite one byte, printable or anything
        pat_bytes[$urandom_range(0, pat_bytes.size() - 1)] =
          8'($urandom_range(0, 1) ? $urandom_range(32, 127) : $urandom_range(0, 255));
      end else if (kind == 8) begin
        // cut the pattern short
        while (pat_bytes.size() > 1 && $urandom_range(0, 3) != 0) void'(pat_bytes.pop_back());
      end else if (kind == 9) begin
        pat_bytes.delete();
        repeat ($urandom_range(1, 8)) pat_bytes.push_back(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 1) == 1) pat_bytes.push_front(CH_SLASH);
      end
      calm = ($urandom_range(0, 4) == 0);
      send_pattern(calm);
    end

    in_valid <= 1'b0;
    // one edge so the checker has seen the last beat
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("testbench: %0d patterns in %0d bytes, %0d results compared (%0d well formed)",
             patterns_sent, bytes_sent, verdicts_checked, clean_verdicts);
    $display("testbench: %0d failures, %0d results still expected", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
